[rtl/tsq_pkg.sv]
package tsq_pkg;

  // Store size and burst limit
  localparam int CAPACITY    = 16;
  localparam int MAX_RESULTS = 16;

  // Derived widths
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int NUM_W = $clog2(MAX_RESULTS + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam int TIME_W = 16;
  localparam int KIND_W = 2;
  localparam int ID_W   = 8;

  // Command codes
  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Entry kind codes
  localparam logic [KIND_W-1:0] KIND_NORMAL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SPECIAL = 2'd1;

  typedef struct packed {
    logic [TIME_W-1:0] rtime;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef enum logic [2:0] {
    RK_ACCEPT  = 3'd0,
    RK_FULL    = 3'd1,
    RK_NORMAL  = 3'd2,
    RK_SPECIAL = 3'd3,
    RK_DISCARD = 3'd4,
    RK_NONE    = 3'd5
  } res_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_START,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_REL_RD,
    ST_REL_CHK
  } state_t;

  // Ring store access, logical indices relative to the head
  typedef struct packed {
    logic             rd_en;
    logic [CNT_W-1:0] rd_lidx;
    logic             wr_en;
    logic [CNT_W-1:0] wr_lidx;
  } ring_req_t;

  // Logical slot to physical slot, wrapping at CAPACITY
  function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] lidx);
    logic [SUM_W-1:0] s;
    s = SUM_W'(head) + SUM_W'(lidx);
    if (s >= SUM_W'(CAPACITY)) begin
      s = s - SUM_W'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  // Route a released entry by its kind
  function automatic res_kind_t route_kind(input logic [KIND_W-1:0] kind);
    res_kind_t rk;
    case (kind)
      KIND_NORMAL:  rk = RK_NORMAL;
      KIND_SPECIAL: rk = RK_SPECIAL;
      default:      rk = RK_DISCARD;
    endcase
    return rk;
  endfunction

endpackage

[rtl/tsq_ring.sv]
module tsq_ring
  import tsq_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] head,
  input  ring_req_t        req,
  input  entry_t           wr_data,
  output entry_t           rd_data
);

  entry_t mem [CAPACITY];
  entry_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[phys_idx(head, req.wr_lidx)] <= wr_data;
    end
  end

  // Registered read port, holds when not read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[phys_idx(head, req.rd_lidx)];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/timed_release_sorted_queue_unit.sv]
// Timed release sorted queue.
// Input beats (in_*): in_tuser selects insert (0) or release (1). An insert
// places the entry after all stored entries with a return time at or below
// its own; a full store rejects it. A release pops, in order, every entry due
// at in_tdata current_time, at most MAX_RESULTS per beat.
// Output beats (out_*): out_tuser is the result kind, out_tlast closes the run
// of results of one input beat, out_tdata carries the released id and whether
// entries remain. One output beat for an insert; one per released entry, or
// a single "nothing due" beat, for a release.
// Storage: entries live in a ring memory with one write port and one registered
// read port. An insert scans back from the tail and shifts each stored entry
// with a later time up one slot; into an empty or a full store it does no scan.
// A release reads and checks the head for each entry until one is not due or
// the limit is hit. The next beat is taken only in idle, entered as the last result is registered.
// Reset empties the queue at once; no clearing pass. When the receiver stalls
// the result sits in the output register and the sequencer waits for it.
module timed_release_sorted_queue_unit
  import tsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: return_time[15:0], car_kind[17:16], hospital_id[25:18],
  //           current_time[41:26], zero pad
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [0:0]  in_tuser,   // cmd[0]
  // out_tdata: released_id[7:0], active[8], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic [2:0]  out_tuser,  // result_kind[2:0]
  output logic        out_tlast
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  hole_r, hole_nxt;
  logic [NUM_W-1:0]  n_r, n_nxt;
  entry_t            new_r, new_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;

  logic              pend_valid_r, pend_valid_nxt;
  res_kind_t         pend_kind_r, pend_kind_nxt;
  logic [ID_W-1:0]   pend_id_r, pend_id_nxt;
  logic              pend_active_r, pend_active_nxt;

  logic              out_valid_r, out_valid_nxt;
  res_kind_t         out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_active_r, out_active_nxt;

  ring_req_t         req;
  entry_t            wr_data;
  entry_t            rd_data;
  logic              wr_sel_new;
  logic              slot_free;
  logic              due;
  logic              rel_more;
  logic              full;
  logic              later;

  tsq_ring u_ring (
    .clk     (clk),
    .head    (head_r),
    .req     (req),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // Shared compare conditions
  assign slot_free = !out_valid_r || out_tready;
  assign due       = rd_data.rtime <= now_r;
  assign later     = rd_data.rtime > new_r.rtime;
  assign rel_more  = (count_r != '0) && (n_r != NUM_W'(MAX_RESULTS));
  assign full      = count_r == CNT_W'(CAPACITY);
  assign wr_data   = wr_sel_new ? new_r : rd_data;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_tuser[0] == CMD_INSERT) ? ST_INS_START : ST_REL_RD;
        end
      end
      ST_INS_START: begin
        if (full || count_r == '0) begin
          if (slot_free) state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (later) begin
          if (hole_r == CNT_W'(1)) state_nxt = ST_INS_PUT;
        end else if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_INS_PUT: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      ST_REL_RD: begin
        if (rel_more) begin
          state_nxt = ST_REL_CHK;
        end else if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REL_CHK: begin
        if (due) begin
          if (!pend_valid_r || slot_free) state_nxt = ST_REL_RD;
        end else if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and result control
  always_comb begin
    count_nxt       = count_r;
    head_nxt        = head_r;
    hole_nxt        = hole_r;
    n_nxt           = n_r;
    new_nxt         = new_r;
    now_nxt         = now_r;
    pend_valid_nxt  = pend_valid_r;
    pend_kind_nxt   = pend_kind_r;
    pend_id_nxt     = pend_id_r;
    pend_active_nxt = pend_active_r;
    req             = '0;
    wr_sel_new      = 1'b0;
    in_tready       = 1'b0;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_kind_nxt    = out_kind_r;
    out_id_nxt      = out_id_r;
    out_last_nxt    = out_last_r;
    out_active_nxt  = out_active_r;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          new_nxt.rtime  = in_tdata[15:0];
          new_nxt.kind   = in_tdata[17:16];
          new_nxt.id     = in_tdata[25:18];
          now_nxt        = in_tdata[41:26];
          n_nxt          = '0;
          pend_valid_nxt = 1'b0;
        end
      end

      // Full check, direct write into an empty store, or first read of the tail entry
      ST_INS_START: begin
        if (full) begin
          if (slot_free) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = RK_FULL;
            out_id_nxt     = '0;
            out_last_nxt   = 1'b1;
            out_active_nxt = 1'b1;
          end
        end else if (count_r == '0) begin
          if (slot_free) begin
            req.wr_en      = 1'b1;
            req.wr_lidx    = '0;
            wr_sel_new     = 1'b1;
            count_nxt      = count_r + CNT_W'(1);
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = RK_ACCEPT;
            out_id_nxt     = '0;
            out_last_nxt   = 1'b1;
            out_active_nxt = 1'b1;
          end
        end else begin
          req.rd_en   = 1'b1;
          req.rd_lidx = count_r - CNT_W'(1);
          hole_nxt    = count_r;
        end
      end

      // Shift later entries up one slot, one per cycle, else place the new entry
      ST_INS_CMP: begin
        if (later) begin
          req.wr_en   = 1'b1;
          req.wr_lidx = hole_r;
          hole_nxt    = hole_r - CNT_W'(1);
          if (hole_r != CNT_W'(1)) begin
            req.rd_en   = 1'b1;
            req.rd_lidx = hole_r - CNT_W'(2);
          end
        end else if (slot_free) begin
          req.wr_en      = 1'b1;
          req.wr_lidx    = hole_r;
          wr_sel_new     = 1'b1;
          count_nxt      = count_r + CNT_W'(1);
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = RK_ACCEPT;
          out_id_nxt     = '0;
          out_last_nxt   = 1'b1;
          out_active_nxt = 1'b1;
        end
      end

      // New entry goes to the front
      ST_INS_PUT: begin
        if (slot_free) begin
          req.wr_en      = 1'b1;
          req.wr_lidx    = '0;
          wr_sel_new     = 1'b1;
          count_nxt      = count_r + CNT_W'(1);
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = RK_ACCEPT;
          out_id_nxt     = '0;
          out_last_nxt   = 1'b1;
          out_active_nxt = 1'b1;
        end
      end

      // Read the head, or close the run
      ST_REL_RD: begin
        if (rel_more) begin
          req.rd_en   = 1'b1;
          req.rd_lidx = '0;
        end else if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          if (pend_valid_r) begin
            out_kind_nxt   = pend_kind_r;
            out_id_nxt     = pend_id_r;
            out_active_nxt = pend_active_r;
          end else begin
            out_kind_nxt   = RK_NONE;
            out_id_nxt     = '0;
            out_active_nxt = count_r != '0;
          end
        end
      end

      // Pop a due head; the held result goes out once its successor is known
      ST_REL_CHK: begin
        if (due) begin
          if (!pend_valid_r || slot_free) begin
            if (pend_valid_r) begin
              out_valid_nxt  = 1'b1;
              out_kind_nxt   = pend_kind_r;
              out_id_nxt     = pend_id_r;
              out_last_nxt   = 1'b0;
              out_active_nxt = pend_active_r;
            end
            pend_valid_nxt  = 1'b1;
            pend_kind_nxt   = route_kind(rd_data.kind);
            pend_id_nxt     = rd_data.id;
            pend_active_nxt = count_r != CNT_W'(1);
            count_nxt       = count_r - CNT_W'(1);
            head_nxt        = (head_r == IDX_W'(CAPACITY - 1)) ? '0 : head_r + IDX_W'(1);
            n_nxt           = n_r + NUM_W'(1);
          end
        end else if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          if (pend_valid_r) begin
            out_kind_nxt   = pend_kind_r;
            out_id_nxt     = pend_id_r;
            out_active_nxt = pend_active_r;
          end else begin
            out_kind_nxt   = RK_NONE;
            out_id_nxt     = '0;
            out_active_nxt = count_r != '0;
          end
        end
      end

      default: begin
        pend_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      head_r       <= '0;
      hole_r       <= '0;
      n_r          <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      head_r       <= head_nxt;
      hole_r       <= hole_nxt;
      n_r          <= n_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    new_r         <= new_nxt;
    now_r         <= now_nxt;
    pend_kind_r   <= pend_kind_nxt;
    pend_id_r     <= pend_id_nxt;
    pend_active_r <= pend_active_nxt;
    out_kind_r    <= out_kind_nxt;
    out_id_r      <= out_id_nxt;
    out_last_r    <= out_last_nxt;
    out_active_r  <= out_active_nxt;
  end

  // Output beat
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'b0, out_active_r, out_id_r};

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_hole_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS_CMP) |-> (hole_r != '0 && hole_r <= count_r))
    else $error("insert hole out of range");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_valid_r)
    else $error("held release result left behind");

  a_burst_limit: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NUM_W'(MAX_RESULTS))
    else $error("release burst above limit");

  a_pop_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REL_CHK && state_nxt == ST_REL_RD) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("pop did not reduce the count");

endmodule
